// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define GDBSA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define GDBSA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gdbsa_pkg.sv =====
`timescale 1ns / 1ps

package gdbsa_pkg;

    localparam int SIZE_BITS   = 7;
    localparam int CMD_W       = 2;
    localparam int GROUP_IDX_W = 6;
    localparam int BIN_NUM_W   = 7;

    localparam logic [CMD_W-1:0] CMD_LOAD_GROUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_BIN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SOLVE      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ       = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [SIZE_BITS-1:0] value;
    } gdbsa_in_t;

    typedef struct packed {
        logic                   feasible;
        logic                   entry_valid;
        logic [GROUP_IDX_W-1:0] group_index;
        logic [BIN_NUM_W-1:0]   bin_number;
        logic                   last_of_group;
        logic                   last_overall;
    } gdbsa_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_group;
        logic load_bin;
        logic solve_begin;
        logic rd_begin;
        logic scan_start;
        logic init_scan;
        logic pick_scan;
        logic seat_scan;
        logic pick_take;
        logic seat_apply;
        logic fail;
        logic grp_write;
        logic finish;
        logic skip_addr;
        logic skip_next;
        logic rd_check;
        logic out_load;
    } gdbsa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic sum_ok;
        logic more_rounds;
        logic ok;
        logic best_zero;
        logic bin_found;
        logic need_last;
        logic solved_ok;
        logic ptr_at_end;
        logic spg_nonzero;
        logic rd_valid;
        logic rd_last_group;
        logic out_free;
    } gdbsa_status_t;

endpackage

// ===== src/gdbsa_datapath.sv =====
`timescale 1ns / 1ps

module gdbsa_datapath import gdbsa_pkg::*; #(
    parameter int MAX_GROUPS = 64,
    parameter int MAX_BINS   = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  gdbsa_in_t     s_data,
    input  logic          m_ready,
    output logic          m_valid,
    output gdbsa_out_t    m_data,
    input  gdbsa_cmd_t    cmd,
    output gdbsa_status_t st
);

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = ((GW > BW) ? GW : BW) + 1;
    localparam int SW = CW + SIZE_BITS;
    localparam int SEAT_DEPTH = MAX_GROUPS * (2 ** BW);
    localparam logic [GW:0] MAXG_C = MAX_GROUPS[GW:0];
    localparam logic [BW:0] MAXB_C = MAX_BINS[BW:0];

    // Storage.
    logic [SIZE_BITS-1:0] gs_mem   [MAX_GROUPS];
    logic [SIZE_BITS-1:0] cap_mem  [MAX_BINS];
    logic [SIZE_BITS-1:0] rem_mem  [MAX_BINS];
    logic [BW:0]          spg_mem  [MAX_GROUPS];
    logic [BW-1:0]        seat_mem [SEAT_DEPTH];

    logic [SIZE_BITS-1:0] gs_rd_reg, cap_rd_reg, rem_rd_reg;
    logic [BW:0]          spg_rd_reg;
    logic [BW-1:0]        seat_rd_reg;

    logic                 gs_we, cap_we, rem_we, spg_we, seat_we;
    logic [GW-1:0]        gs_waddr, spg_waddr;
    logic [BW-1:0]        cap_waddr, rem_waddr;
    logic [SIZE_BITS-1:0] rem_wdata;
    logic [BW:0]          spg_wdata;

    logic [GW:0]          gl_reg, gl_next, bl_base_g, gl_base;
    logic [BW:0]          bl_reg, bl_next, bl_base;
    logic                 solved_ok_reg, solved_ok_next;
    logic                 solve_done_reg, solve_done_next;
    logic [GW:0]          ptr_g_reg, ptr_g_next;
    logic [BW:0]          k_reg, k_next;
    logic [CW-1:0]        idx_reg, idx_next, pidx_reg, pidx_next, scan_n;
    logic                 pv_reg, pv_next;
    logic [SW-1:0]        dem_reg, dem_next, capsum_reg, capsum_next;
    logic [GW:0]          round_reg, round_next;
    logic                 ok_reg, ok_next;
    logic [MAX_GROUPS-1:0] taken_reg, taken_next;
    logic [MAX_BINS-1:0]  used_reg, used_next;
    logic [GW-1:0]        best_g_reg, best_g_next;
    logic [SIZE_BITS-1:0] best_gs_reg, best_gs_next;
    logic                 found_reg, found_next;
    logic [BW-1:0]        bb_reg, bb_next;
    logic [SIZE_BITS-1:0] bb_rem_reg, bb_rem_next;
    logic                 bfound_reg, bfound_next;
    logic [SIZE_BITS-1:0] need_reg, need_next;
    logic [BW:0]          cnt_reg, cnt_next;
    logic                 rd_ctx_reg, rd_ctx_next;
    gdbsa_out_t           res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    gdbsa_out_t           m_data_reg, m_data_next;
    logic                 rd_valid, rd_last;

    assign gl_base   = solve_done_reg ? '0 : gl_reg;
    assign bl_base   = solve_done_reg ? '0 : bl_reg;
    assign bl_base_g = (CW > 0) ? gl_base : gl_base;

    always_comb begin
        scan_n = '0;
        if (cmd.init_scan) begin
            scan_n = (CW'(gl_reg) > CW'(bl_reg)) ? CW'(gl_reg) : CW'(bl_reg);
        end else if (cmd.pick_scan) begin
            scan_n = CW'(gl_reg);
        end else if (cmd.seat_scan) begin
            scan_n = CW'(bl_reg);
        end
    end

    assign rd_valid = (ptr_g_reg < gl_reg) && (k_reg < spg_rd_reg);
    assign rd_last  = ({1'b0, k_reg} + 1'b1) >= {1'b0, spg_rd_reg};

    always_comb begin
        gl_next = gl_reg;           bl_next = bl_reg;
        solved_ok_next = solved_ok_reg;
        solve_done_next = solve_done_reg;
        ptr_g_next = ptr_g_reg;     k_next = k_reg;
        idx_next = idx_reg;         pidx_next = pidx_reg;   pv_next = pv_reg;
        dem_next = dem_reg;         capsum_next = capsum_reg;
        round_next = round_reg;     ok_next = ok_reg;
        taken_next = taken_reg;     used_next = used_reg;
        best_g_next = best_g_reg;   best_gs_next = best_gs_reg;
        found_next = found_reg;
        bb_next = bb_reg;           bb_rem_next = bb_rem_reg;
        bfound_next = bfound_reg;
        need_next = need_reg;       cnt_next = cnt_reg;
        rd_ctx_next = rd_ctx_reg;   res_next = res_reg;
        m_data_next = m_data_reg;
        gs_we = 1'b0;   gs_waddr = gl_base[GW-1:0];
        cap_we = 1'b0;  cap_waddr = bl_base[BW-1:0];
        rem_we = 1'b0;  rem_waddr = pidx_reg[BW-1:0];  rem_wdata = cap_rd_reg;
        spg_we = 1'b0;  spg_waddr = idx_reg[GW-1:0];   spg_wdata = '0;
        seat_we = 1'b0;

        // A load after a solve starts a new data set.
        if (cmd.load_group || cmd.load_bin) begin
            if (solve_done_reg) begin
                gl_next = '0;
                bl_next = '0;
                solved_ok_next = 1'b0;
                solve_done_next = 1'b0;
                ptr_g_next = '0;
                k_next = '0;
            end
            if (cmd.load_group && bl_base_g < MAXG_C) begin
                gs_we = 1'b1;
                gl_next = gl_base + 1'b1;
            end
            if (cmd.load_bin && bl_base < MAXB_C) begin
                cap_we = 1'b1;
                bl_next = bl_base + 1'b1;
            end
        end

        if (cmd.solve_begin) begin
            dem_next = '0;
            capsum_next = '0;
            round_next = '0;
            ok_next = 1'b1;
            taken_next = '0;
        end

        // Shared scan counter; read data is registered and follows the address in the next cycle.
        if (cmd.scan_start) begin
            idx_next = '0;
            pv_next = 1'b0;
            found_next = 1'b0;
            bfound_next = 1'b0;
        end else if (cmd.init_scan || cmd.pick_scan || cmd.seat_scan) begin
            pv_next = idx_reg < scan_n;
            pidx_next = idx_reg;
            if (idx_reg < scan_n) begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.init_scan) begin
            if (idx_reg < CW'(gl_reg)) begin
                spg_we = 1'b1;
            end
            if (pv_reg) begin
                if (pidx_reg < CW'(gl_reg)) begin
                    dem_next = dem_reg + SW'(gs_rd_reg);
                end
                if (pidx_reg < CW'(bl_reg)) begin
                    capsum_next = capsum_reg + SW'(cap_rd_reg);
                    rem_we = 1'b1;
                end
            end
        end

        if (cmd.pick_scan && pv_reg && !taken_reg[pidx_reg[GW-1:0]]) begin
            if (!found_reg || gs_rd_reg >= best_gs_reg) begin
                best_g_next = pidx_reg[GW-1:0];
                best_gs_next = gs_rd_reg;
                found_next = 1'b1;
            end
        end

        if (cmd.pick_take) begin
            taken_next[best_g_reg] = 1'b1;
            need_next = best_gs_reg;
            cnt_next = '0;
            used_next = '0;
            round_next = round_reg + 1'b1;
        end

        // Larger remaining room wins; on a tie the later bin wins.
        if (cmd.seat_scan && pv_reg && !used_reg[pidx_reg[BW-1:0]] && rem_rd_reg != '0) begin
            if (!bfound_reg || rem_rd_reg >= bb_rem_reg) begin
                bb_next = pidx_reg[BW-1:0];
                bb_rem_next = rem_rd_reg;
                bfound_next = 1'b1;
            end
        end

        if (cmd.seat_apply) begin
            rem_we = 1'b1;
            rem_waddr = bb_reg;
            rem_wdata = bb_rem_reg - 1'b1;
            used_next[bb_reg] = 1'b1;
            seat_we = 1'b1;
            cnt_next = cnt_reg + 1'b1;
            need_next = need_reg - 1'b1;
        end

        if (cmd.fail) begin
            ok_next = 1'b0;
        end

        if (cmd.grp_write) begin
            spg_we = 1'b1;
            spg_waddr = best_g_reg;
            spg_wdata = cnt_reg;
        end

        if (cmd.finish) begin
            solved_ok_next = ok_reg;
            solve_done_next = 1'b1;
            ptr_g_next = '0;
            k_next = '0;
            rd_ctx_next = 1'b0;
            res_next = '0;
            res_next.feasible = ok_reg;
        end

        if (cmd.rd_begin) begin
            rd_ctx_next = 1'b1;
            res_next = '0;
            res_next.feasible = solved_ok_reg;
        end

        if (cmd.skip_addr && ptr_g_reg >= gl_reg && rd_ctx_reg) begin
            res_next.last_overall = 1'b1;
        end

        if (cmd.skip_next) begin
            ptr_g_next = ptr_g_reg + 1'b1;
        end

        if (cmd.rd_check && rd_valid) begin
            res_next.entry_valid = 1'b1;
            res_next.group_index = GROUP_IDX_W'(ptr_g_reg);
            res_next.bin_number = BIN_NUM_W'(seat_rd_reg) + 1'b1;
            res_next.last_of_group = rd_last;
            if (rd_last) begin
                ptr_g_next = ptr_g_reg + 1'b1;
                k_next = '0;
            end else begin
                k_next = k_reg + 1'b1;
            end
        end

        if (cmd.out_load) begin
            m_data_next = res_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gl_reg <= '0;
            bl_reg <= '0;
            solved_ok_reg <= 1'b0;
            solve_done_reg <= 1'b0;
            ptr_g_reg <= '0;
            k_reg <= '0;
            idx_reg <= '0;
            pv_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            rd_ctx_reg <= 1'b0;
        end else begin
            gl_reg <= gl_next;
            bl_reg <= bl_next;
            solved_ok_reg <= solved_ok_next;
            solve_done_reg <= solve_done_next;
            ptr_g_reg <= ptr_g_next;
            k_reg <= k_next;
            idx_reg <= idx_next;
            pv_reg <= pv_next;
            m_valid_reg <= m_valid_next;
            rd_ctx_reg <= rd_ctx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= pidx_next;
        dem_reg <= dem_next;
        capsum_reg <= capsum_next;
        round_reg <= round_next;
        ok_reg <= ok_next;
        taken_reg <= taken_next;
        used_reg <= used_next;
        best_g_reg <= best_g_next;
        best_gs_reg <= best_gs_next;
        found_reg <= found_next;
        bb_reg <= bb_next;
        bb_rem_reg <= bb_rem_next;
        bfound_reg <= bfound_next;
        need_reg <= need_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (gs_we) begin
            gs_mem[gs_waddr] <= s_data.value;
        end
        gs_rd_reg <= gs_mem[idx_reg[GW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cap_we) begin
            cap_mem[cap_waddr] <= s_data.value;
        end
        cap_rd_reg <= cap_mem[idx_reg[BW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (rem_we) begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        rem_rd_reg <= rem_mem[idx_reg[BW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (spg_we) begin
            spg_mem[spg_waddr] <= spg_wdata;
        end
        spg_rd_reg <= spg_mem[ptr_g_reg[GW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (seat_we) begin
            seat_mem[{best_g_reg, cnt_reg[BW-1:0]}] <= bb_reg;
        end
        seat_rd_reg <= seat_mem[{ptr_g_reg[GW-1:0], k_reg[BW-1:0]}];
    end

    always_comb begin
        st.scan_done     = !pv_reg && (idx_reg >= scan_n);
        st.sum_ok        = dem_reg <= capsum_reg;
        st.more_rounds   = round_reg < gl_reg;
        st.ok            = ok_reg;
        st.best_zero     = best_gs_reg == '0;
        st.bin_found     = bfound_reg;
        st.need_last     = need_reg == SIZE_BITS'(1);
        st.solved_ok     = solved_ok_reg;
        st.ptr_at_end    = ptr_g_reg >= gl_reg;
        st.spg_nonzero   = spg_rd_reg != '0;
        st.rd_valid      = rd_valid;
        st.rd_last_group = rd_last;
        st.out_free      = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/gdbsa_ctrl.sv =====
`timescale 1ns / 1ps

module gdbsa_ctrl import gdbsa_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CMD_W-1:0] in_command,
    input  gdbsa_status_t    st,
    output gdbsa_cmd_t       cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_INIT     = 13'b0000000000010,
        S_PICK     = 13'b0000000000100,
        S_PICK_END = 13'b0000000001000,
        S_SEAT     = 13'b0000000010000,
        S_SEAT_END = 13'b0000000100000,
        S_GRP_END  = 13'b0000001000000,
        S_FINISH   = 13'b0000010000000,
        S_SKIP_ADR = 13'b0000100000000,
        S_SKIP_CHK = 13'b0001000000000,
        S_RD_ADR   = 13'b0010000000000,
        S_RD_CHK   = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (in_command)
                        CMD_LOAD_GROUP: cmd.load_group = 1'b1;
                        CMD_LOAD_BIN:   cmd.load_bin = 1'b1;
                        CMD_SOLVE: begin
                            cmd.solve_begin = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next = S_INIT;
                        end
                        CMD_READ: begin
                            cmd.rd_begin = 1'b1;
                            state_next = st.solved_ok ? S_RD_ADR : S_DONE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT: begin
                cmd.init_scan = 1'b1;
                if (st.scan_done) begin
                    if (!st.sum_ok) begin
                        cmd.fail = 1'b1;
                        state_next = S_FINISH;
                    end else if (st.more_rounds) begin
                        cmd.scan_start = 1'b1;
                        state_next = S_PICK;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_PICK: begin
                cmd.pick_scan = 1'b1;
                if (st.scan_done) begin
                    state_next = S_PICK_END;
                end
            end
            S_PICK_END: begin
                cmd.pick_take = 1'b1;
                if (st.best_zero) begin
                    state_next = S_GRP_END;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SEAT;
                end
            end
            S_SEAT: begin
                cmd.seat_scan = 1'b1;
                if (st.scan_done) begin
                    state_next = S_SEAT_END;
                end
            end
            S_SEAT_END: begin
                if (!st.bin_found) begin
                    cmd.fail = 1'b1;
                    state_next = S_GRP_END;
                end else begin
                    cmd.seat_apply = 1'b1;
                    if (st.need_last) begin
                        state_next = S_GRP_END;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next = S_SEAT;
                    end
                end
            end
            S_GRP_END: begin
                cmd.grp_write = 1'b1;
                if (st.ok && st.more_rounds) begin
                    cmd.scan_start = 1'b1;
                    state_next = S_PICK;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_SKIP_ADR;
            end
            S_SKIP_ADR: begin
                cmd.skip_addr = 1'b1;
                state_next = st.ptr_at_end ? S_DONE : S_SKIP_CHK;
            end
            S_SKIP_CHK: begin
                if (st.spg_nonzero) begin
                    state_next = S_DONE;
                end else begin
                    cmd.skip_next = 1'b1;
                    state_next = S_SKIP_ADR;
                end
            end
            S_RD_ADR: begin
                state_next = S_RD_CHK;
            end
            S_RD_CHK: begin
                cmd.rd_check = 1'b1;
                state_next = (st.rd_valid && st.rd_last_group) ? S_SKIP_ADR : S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/greedy_distinct_bin_seat_assigner_unit.sv =====
`timescale 1ns / 1ps
// Greedy distinct-bin seat assigner.
// Input words (s_valid/s_ready/s_data) carry a command and a value: load a
// group size, load a bin capacity, solve, or read the next seat. Result words
// (m_valid/m_ready/m_data) come out for solve and read only; loads give none.
// A read fetches the next seat from the seat memory and, after a group's last
// seat, steps the pointer over the empty groups that follow. A solve first
// scans the group size and bin capacity memories together; then every group
// pick scans the group size memory and every seat scans the bin memory once,
// one entry per cycle. At the end it steps over the empty groups ahead of the
// first seated one.
// The block works on one word at a time; a finished result sits in the output
// register while the next word is accepted, and the controller holds in its
// done state while the receiver stalls with a result still pending.
// Reset clears the group and bin counts and the solved flag; the memories are
// not cleared and are only read after they have been written.
module greedy_distinct_bin_seat_assigner_unit import gdbsa_pkg::*; #(
    parameter int MAX_GROUPS = 64,
    parameter int MAX_BINS   = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  gdbsa_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output gdbsa_out_t m_data
);

    gdbsa_cmd_t    cmd;
    gdbsa_status_t st;

    gdbsa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .in_command (s_data.command),
        .st         (st),
        .cmd        (cmd)
    );

    gdbsa_datapath #(
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_BINS   (MAX_BINS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

// ===== src/gdbsa_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gdbsa_checker import gdbsa_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input gdbsa_in_t  s_data,
    input logic       m_valid,
    input logic       m_ready,
    input gdbsa_out_t m_data
);

    `GDBSA_ASSERT_NR(a_reset_clears_valid, aclk, !aresetn |=> !m_valid, "m_valid after reset")
    `GDBSA_ASSERT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled word changed")
    `GDBSA_ASSERT(a_entry_needs_feasible, aclk, aresetn, m_valid && m_data.entry_valid |-> m_data.feasible, "entry without feasible")
    `GDBSA_ASSERT(a_last_overall_ends_group, aclk, aresetn, m_valid && m_data.last_overall |-> m_data.last_of_group && m_data.entry_valid, "last overall not group end")
    `GDBSA_ASSERT(a_empty_word_zero, aclk, aresetn, m_valid && !m_data.entry_valid |-> m_data.bin_number == '0 && m_data.group_index == '0 && !m_data.last_of_group, "empty word not zero")

endmodule

bind greedy_distinct_bin_seat_assigner_unit gdbsa_checker u_gdbsa_checker (.*);
